### rtl/rfa_pkg.sv
// package for the rational fraction alu: types, opcodes, states
`default_nettype none
package rfa_pkg;
  localparam int unsigned WordBits = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_RED = 4'd4,
    OP_EQ = 4'd5, OP_NE = 4'd6, OP_LT = 4'd7, OP_GT = 4'd8
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_COMB, ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
  } state_e;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic               cmp_true;
    logic               div_error;
  } res_t;
endpackage
`default_nettype wire

### rtl/rational_fraction_alu.sv
// rational fraction alu top level: sequencer around one shared multiplier and divide step
// channel | direction | handshake          | payload
// request | in        | start_i, busy_o    | req_i  (rfa_pkg::req_t)
// result  | out       | done_o (strobe)    | res_o  (rfa_pkg::res_t)
// sequence: add/sub/mul/div pass through MUL1, MUL2 and COMB on the shared multiplier, then DONE;
//   lt/gt go from MUL2 to DONE; eq/ne and unused opcodes go from IDLE straight to DONE
// reduce: binary gcd one step per cycle, then two restoring divisions of the numerator
//   and denominator magnitudes by the gcd in one shared subtract unit
// reset clears the sequencer to idle; payload registers hold no reset
// busy_o is high from acceptance until the strobe cycle ends; receiver cannot stall
`default_nettype none
module rational_fraction_alu (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire rfa_pkg::req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output rfa_pkg::res_t     res_o
);
  localparam int unsigned W = rfa_pkg::WordBits;

  rfa_pkg::state_e state_q, state_d;
  rfa_pkg::req_t   req_q;
  rfa_pkg::res_t   res_q, res_d;
  logic [W-1:0]    p1_q, p1_d;          // first cross product
  logic [W-1:0]    gx_q, gx_d, gy_q, gy_d; // gcd operands
  logic [5:0]      gk_q, gk_d;          // common power of two
  logic [W-1:0]    g_q, g_d;            // gcd
  logic [W-1:0]    quo_q, quo_d, rem_q, rem_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            neg_q, neg_d;

  // shared multiplier operand selection
  logic [W-1:0] mx, my, mprod;
  logic [2*W-1:0] mfull;
  logic [W-1:0] an, ad, bn, bd;
  logic [W-1:0] abs_an, abs_ad;
  logic [W:0]   rsub;
  logic [W-1:0] rsh;

  assign an = req_q.a_num[W-1:0];
  assign ad = req_q.a_den[W-1:0];
  assign bn = req_q.b_num[W-1:0];
  assign bd = req_q.b_den[W-1:0];
  assign abs_an = an[W-1] ? (~an + 1'b1) : an;
  assign abs_ad = ad[W-1] ? (~ad + 1'b1) : ad;

  always_comb begin
    mx = an;
    my = bd;
    if (state_q == rfa_pkg::ST_MUL2) begin
      unique case (rfa_pkg::opcode_e'(req_q.opcode))
        rfa_pkg::OP_MUL: begin mx = an; my = bn; end
        rfa_pkg::OP_DIV: begin mx = ad; my = bn; end
        default:         begin mx = bn; my = ad; end
      endcase
    end else if (state_q == rfa_pkg::ST_COMB) begin
      mx = ad;
      my = bd;
    end
  end
  assign mfull = mx * my;
  assign mprod = mfull[W-1:0];

  // restoring divide step on the dividend magnitude
  logic [W-1:0] dvd;
  assign dvd = (state_q == rfa_pkg::ST_DIVN) ? abs_an : abs_ad;
  assign rsh = {rem_q[W-2:0], dvd[cnt_q[4:0]]};
  assign rsub = {1'b0, rsh} - {1'b0, g_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfa_pkg::ST_IDLE: if (start_i) begin
        priority case (req_i.opcode)
          4'(rfa_pkg::OP_RED):
            state_d = rfa_pkg::ST_GCD;
          4'(rfa_pkg::OP_ADD), 4'(rfa_pkg::OP_SUB), 4'(rfa_pkg::OP_MUL),
          4'(rfa_pkg::OP_DIV), 4'(rfa_pkg::OP_LT), 4'(rfa_pkg::OP_GT):
            state_d = rfa_pkg::ST_MUL1;
          default: state_d = rfa_pkg::ST_DONE;
        endcase
      end
      rfa_pkg::ST_MUL1: state_d = rfa_pkg::ST_MUL2;
      rfa_pkg::ST_MUL2: state_d = (req_q.opcode == 4'(rfa_pkg::OP_LT) ||
                                   req_q.opcode == 4'(rfa_pkg::OP_GT)) ?
                                  rfa_pkg::ST_DONE : rfa_pkg::ST_COMB;
      rfa_pkg::ST_COMB: state_d = rfa_pkg::ST_DONE;
      rfa_pkg::ST_GCD:  if (gx_q == '0 || gy_q == '0) state_d = rfa_pkg::ST_DIVN;
      rfa_pkg::ST_DIVN: if (cnt_q == '0) state_d = rfa_pkg::ST_DIVD;
      rfa_pkg::ST_DIVD: if (cnt_q == '0) state_d = rfa_pkg::ST_DONE;
      rfa_pkg::ST_DONE: state_d = rfa_pkg::ST_IDLE;
      default:          state_d = rfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res_d = res_q;
    p1_d = p1_q;
    gx_d = gx_q; gy_d = gy_q; gk_d = gk_q; g_d = g_q;
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q; neg_d = neg_q;
    unique case (state_q)
      rfa_pkg::ST_IDLE: if (start_i) begin
        res_d = '0;
        gk_d = '0;
        cnt_d = 6'(W - 1);
        rem_d = '0;
        if (req_i.opcode == 4'(rfa_pkg::OP_EQ))
          res_d.cmp_true = (req_i.a_num[W-1:0] == req_i.b_num[W-1:0]) &&
                           (req_i.a_den[W-1:0] == req_i.b_den[W-1:0]);
        if (req_i.opcode == 4'(rfa_pkg::OP_NE))
          res_d.cmp_true = !((req_i.a_num[W-1:0] == req_i.b_num[W-1:0]) &&
                             (req_i.a_den[W-1:0] == req_i.b_den[W-1:0]));
        // gcd is forced to 1 when either part is zero
        if (req_i.a_num[W-1:0] == '0 || req_i.a_den[W-1:0] == '0) begin
          gx_d = W'(1); gy_d = '0;
        end else begin
          gx_d = req_i.a_num[W-1] ? (~req_i.a_num[W-1:0] + 1'b1) : req_i.a_num[W-1:0];
          gy_d = req_i.a_den[W-1] ? (~req_i.a_den[W-1:0] + 1'b1) : req_i.a_den[W-1:0];
        end
      end
      rfa_pkg::ST_MUL1: p1_d = mprod;
      rfa_pkg::ST_MUL2: begin
        unique case (rfa_pkg::opcode_e'(req_q.opcode))
          rfa_pkg::OP_LT: res_d.cmp_true = $signed(p1_q) < $signed(mprod);
          rfa_pkg::OP_GT: res_d.cmp_true = $signed(p1_q) > $signed(mprod);
          rfa_pkg::OP_ADD: res_d.res_num = 32'($signed(p1_q + mprod));
          rfa_pkg::OP_SUB: res_d.res_num = 32'($signed(p1_q - mprod));
          rfa_pkg::OP_MUL: res_d.res_num = 32'($signed(mprod));
          default: begin
            if (bn == '0) begin
              res_d.res_num = 32'($signed(bn));
              res_d.res_den = 32'($signed(bd));
              res_d.div_error = 1'b1;
            end else begin
              res_d.res_num = 32'($signed(p1_q));
              p1_d = mprod;
            end
          end
        endcase
      end
      rfa_pkg::ST_COMB: begin
        // a flagged divide keeps b's denominator
        if (req_q.opcode == 4'(rfa_pkg::OP_DIV)) begin
          if (!res_q.div_error) res_d.res_den = 32'($signed(p1_q));
        end else
          res_d.res_den = 32'($signed(mprod));
      end
      rfa_pkg::ST_GCD: begin
        // binary gcd: one step per cycle
        if (gx_q == '0) begin
          g_d = gy_q << gk_q;
          neg_d = an[W-1];
        end else if (gy_q == '0) begin
          g_d = gx_q << gk_q;
          neg_d = an[W-1];
        end else if (!gx_q[0] && !gy_q[0]) begin
          gx_d = gx_q >> 1; gy_d = gy_q >> 1; gk_d = gk_q + 6'd1;
        end else if (!gx_q[0]) gx_d = gx_q >> 1;
        else if (!gy_q[0]) gy_d = gy_q >> 1;
        else if (gx_q >= gy_q) gx_d = (gx_q - gy_q) >> 1;
        else gy_d = (gy_q - gx_q) >> 1;
      end
      rfa_pkg::ST_DIVN, rfa_pkg::ST_DIVD: begin
        if (!rsub[W]) begin
          rem_d = rsub[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          rem_d = rsh;
          quo_d = {quo_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          cnt_d = 6'(W - 1);
          rem_d = '0;
          if (state_q == rfa_pkg::ST_DIVN) begin
            res_d.res_num = 32'($signed(neg_q ? (~quo_d + 1'b1) : quo_d));
            neg_d = ad[W-1];
          end else
            res_d.res_den = 32'($signed(neg_q ? (~quo_d + 1'b1) : quo_d));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rfa_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rfa_pkg::ST_IDLE && start_i) req_q <= req_i;
    res_q <= res_d; p1_q <= p1_d;
    gx_q <= gx_d; gy_q <= gy_d; gk_q <= gk_d; g_q <= g_d;
    quo_q <= quo_d; rem_q <= rem_d; cnt_q <= cnt_d; neg_q <= neg_d;
  end

  assign busy_o = (state_q != rfa_pkg::ST_IDLE);
  assign done_o = (state_q == rfa_pkg::ST_DONE);
  assign res_o  = res_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("strobe while idle");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double strobe");
  a_err_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.div_error) |-> req_q.opcode == 4'(rfa_pkg::OP_DIV))
    else $error("error flag off divide");
endmodule
`default_nettype wire

### test/rational_fraction_alu_tb.sv
// testbench for the rational fraction alu: random and directed requests checked against a predictor
`timescale 1ns / 1ps
module rational_fraction_alu_tb;

  localparam int unsigned NumRandom = 1530;
  localparam longint unsigned CycleLimit = 2000000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  rfa_pkg::req_t req_i;
  logic busy_o;
  logic done_o;
  rfa_pkg::res_t res_o;

  rational_fraction_alu dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // requests waiting to be driven, results waiting to arrive
  rfa_pkg::req_t pending_reqs[$];
  rfa_pkg::res_t expected_results[$];
  int unsigned error_count;
  longint unsigned cycle_count;
  bit stimulus_done;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // euclid on unsigned magnitudes
  function automatic logic [32:0] gcd_of(logic [32:0] x, logic [32:0] y);
    logic [32:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic [32:0] magnitude(logic signed [31:0] v);
    logic signed [32:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  // fraction arithmetic predictor, all products wrap to 32 bits
  function automatic rfa_pkg::res_t fraction_result(rfa_pkg::req_t r);
    rfa_pkg::res_t o;
    logic signed [31:0] p_ab, p_ba;
    logic [32:0] g;
    longint q_num, q_den;
    o = '0;
    p_ab = r.a_num * r.b_den;
    p_ba = r.b_num * r.a_den;
    case (r.opcode)
      rfa_pkg::OP_ADD: begin
        o.res_num = p_ab + p_ba;
        o.res_den = r.a_den * r.b_den;
      end
      rfa_pkg::OP_SUB: begin
        o.res_num = p_ab - p_ba;
        o.res_den = r.a_den * r.b_den;
      end
      rfa_pkg::OP_MUL: begin
        o.res_num = r.a_num * r.b_num;
        o.res_den = r.a_den * r.b_den;
      end
      rfa_pkg::OP_DIV: begin
        // zero divisor numerator passes b through and flags it
        if (r.b_num == 0) begin
          o.res_num = r.b_num;
          o.res_den = r.b_den;
          o.div_error = 1'b1;
        end else begin
          o.res_num = p_ab;
          o.res_den = r.a_den * r.b_num;
        end
      end
      rfa_pkg::OP_RED: begin
        g = 1;
        if (r.a_num != 0 && r.a_den != 0) g = gcd_of(magnitude(r.a_num), magnitude(r.a_den));
        if (g == 0) g = 1;
        q_num = longint'(r.a_num) / longint'(g);
        q_den = longint'(r.a_den) / longint'(g);
        o.res_num = q_num[31:0];
        o.res_den = q_den[31:0];
      end
      rfa_pkg::OP_EQ: o.cmp_true = (r.a_num == r.b_num && r.a_den == r.b_den);
      rfa_pkg::OP_NE: o.cmp_true = !(r.a_num == r.b_num && r.a_den == r.b_den);
      rfa_pkg::OP_LT: o.cmp_true = (p_ab < p_ba);
      rfa_pkg::OP_GT: o.cmp_true = (p_ab > p_ba);
      default: o = '0;
    endcase
    return o;
  endfunction

  // operand mix: extremes, small values and full random words
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4, 5: return $urandom_range(0, 40) - 20;
      6: return $urandom_range(0, 4000) - 2000;
      default: return $urandom;
    endcase
  endfunction

  function automatic rfa_pkg::req_t fraction_request(logic [3:0] op, logic [31:0] an,
                                                     logic [31:0] ad, logic [31:0] bn,
                                                     logic [31:0] bd);
    rfa_pkg::req_t r;
    r.opcode = op;
    r.a_num = an;
    r.a_den = ad;
    r.b_num = bn;
    r.b_den = bd;
    return r;
  endfunction

  // stimulus: directed corners first, then random requests
  initial begin
    rfa_pkg::req_t r;
    error_count = 0;
    stimulus_done = 1'b0;
    // every opcode on plain values
    for (int op = 0; op < 16; op++)
      pending_reqs.push_back(fraction_request(4'(op), 6, -4, 3, 9));
    // divide with zero numerator in b
    pending_reqs.push_back(fraction_request(rfa_pkg::OP_DIV, 5, 7, 0, -3));
    // reduce with zero numerator, zero denominator, negative parts, most negative word
    pending_reqs.push_back(fraction_request(rfa_pkg::OP_RED, 0, 12, 0, 0));
    pending_reqs.push_back(fraction_request(rfa_pkg::OP_RED, 12, 0, 0, 0));
    pending_reqs.push_back(fraction_request(rfa_pkg::OP_RED, -18, 24, 0, 0));
    pending_reqs.push_back(fraction_request(rfa_pkg::OP_RED, 32'h8000_0000, 32'h8000_0000,
                                            0, 0));
    pending_reqs.push_back(fraction_request(rfa_pkg::OP_RED, 32'h8000_0000, -6, 0, 0));
    // comparisons with wrapped cross products and equal raw parts
    pending_reqs.push_back(fraction_request(rfa_pkg::OP_LT, 32'h7fff_ffff, 32'h7fff_ffff,
                                            -1, 2));
    pending_reqs.push_back(fraction_request(rfa_pkg::OP_GT, 32'h8000_0000, -1,
                                            32'h7fff_ffff, 3));
    pending_reqs.push_back(fraction_request(rfa_pkg::OP_EQ, -5, 32'h8000_0000, -5,
                                            32'h8000_0000));
    for (int i = 0; i < NumRandom; i++) begin
      // mostly legal opcodes, a few unused ones
      r = fraction_request(4'(($urandom_range(0, 19) == 0) ? $urandom_range(9, 15)
                                                             : $urandom_range(0, 8)),
                           pick_word(), pick_word(), pick_word(), pick_word());
      if ((r.opcode == rfa_pkg::OP_EQ || r.opcode == rfa_pkg::OP_NE) &&
          $urandom_range(0, 1)) begin
        r.b_num = r.a_num;
        r.b_den = r.a_den;
      end
      pending_reqs.push_back(r);
    end
    stimulus_done = 1'b1;
  end

  // reset and the end of the run
  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stimulus_done && pending_reqs.size() == 0 && !start_i &&
          expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // driver: request held until accepted, random gap after each
  int unsigned gap_cycles;
  logic busy_seen;    // busy as it stood before the last rising edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i <= '0;
      gap_cycles <= 0;
      busy_seen <= 1'b0;
    end else begin
      busy_seen <= busy_o;
      if (start_i && !busy_seen) begin
        // accepted at the last rising edge
        start_i <= 1'b0;
        gap_cycles <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end else if (!start_i) begin
        if (gap_cycles != 0) begin
          gap_cycles <= gap_cycles - 1;
        end else if (pending_reqs.size() != 0) begin
          start_i <= 1'b1;
          req_i <= pending_reqs.pop_front();
        end
      end
    end
  end

  // monitor: predicts on acceptance, checks on each result strobe
  always @(posedge clk_i) begin
    rfa_pkg::res_t exp_res;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (res_o.res_num !== exp_res.res_num) begin
            $error("res_num expected %0d actual %0d", exp_res.res_num, res_o.res_num);
            error_count++;
          end
          if (res_o.res_den !== exp_res.res_den) begin
            $error("res_den expected %0d actual %0d", exp_res.res_den, res_o.res_den);
            error_count++;
          end
          if (res_o.cmp_true !== exp_res.cmp_true) begin
            $error("cmp_true expected %0b actual %0b", exp_res.cmp_true, res_o.cmp_true);
            error_count++;
          end
          if (res_o.div_error !== exp_res.div_error) begin
            $error("div_error expected %0b actual %0b", exp_res.div_error, res_o.div_error);
            error_count++;
          end
        end
      end
      if (start_i && !busy_o) expected_results.push_back(fraction_result(req_i));
    end
  end

  initial cycle_count = 0;
endmodule

### sim.f
rtl/rfa_pkg.sv
rtl/rational_fraction_alu.sv
test/rational_fraction_alu_tb.sv
